/* design/p2sca_pkg.sv */
`default_nettype none

package p2sca_pkg;

    // Default geometry
    localparam int DEF_HEAP_ADDR_BITS  = 24;
    localparam int DEF_NUM_CLASSES     = 32;
    localparam int DEF_MIN_CHUNK_BYTES = 8;

    // Link store slot is address / 8 (pointer-sized granule)
    localparam int LINK_SHIFT = 3;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_START = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_END   = 2'd1;

    // Command and status codes
    localparam logic CMD_ALLOC  = 1'b0;
    localparam logic CMD_FREE   = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOM = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load;   // latch the request beat
        logic exec;   // class lookup, bump or push
        logic pop;    // link data back, update class head
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pop_needed;
    } dp_status_t;

    // Number of significant bits in x (0 for x == 0)
    function automatic logic [6:0] bit_length(input logic [63:0] x);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) n = 7'(i + 1);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* design/p2sca_ram.sv */
`default_nettype none

module p2sca_ram #(
    parameter int WIDTH  = 25,
    parameter int ADDR_W = 21
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_W];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/p2sca_ctrl.sv */
`default_nettype none

module p2sca_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    output logic                       done,
    output p2sca_pkg::ctrl_cmd_t       cmd,
    input  wire p2sca_pkg::dp_status_t stat
);
    import p2sca_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.pop_needed)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    // Strobe only after a finishing step
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_EXEC || $past(state_reg) == S_POP))
        else $error("result strobe without a finishing step");

    // Pop step only right after the execute step
    a_pop_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> ($past(state_reg) == S_EXEC))
        else $error("pop step not preceded by execute");

    // An accepted beat always moves to execute
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_EXEC))
        else $error("accepted beat did not start execute");

endmodule

`default_nettype wire

/* design/p2sca_dp.sv */
`default_nettype none

module p2sca_dp #(
    parameter int HEAP_ADDR_BITS  = p2sca_pkg::DEF_HEAP_ADDR_BITS,
    parameter int NUM_CLASSES     = p2sca_pkg::DEF_NUM_CLASSES,
    parameter int MIN_CHUNK_BYTES = p2sca_pkg::DEF_MIN_CHUNK_BYTES   // power of two
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire p2sca_pkg::ctrl_cmd_t               cmd,
    output p2sca_pkg::dp_status_t                   stat,
    input  wire logic                               command,
    input  wire logic [HEAP_ADDR_BITS:0]            request_size,
    input  wire logic [HEAP_ADDR_BITS-1:0]          chunk_address,
    input  wire logic                               cfg_wr,
    input  wire logic [p2sca_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [HEAP_ADDR_BITS:0]            cfg_data,
    output logic      [HEAP_ADDR_BITS-1:0]          result_address,
    output logic                                    status,
    output logic      [31:0]                        bytes_in_use
);
    import p2sca_pkg::*;

    localparam int A    = HEAP_ADDR_BITS;
    localparam int RW   = A + 2;                        // rounded size / bump sum
    localparam int HW   = $clog2(NUM_CLASSES);
    localparam int KA   = $clog2(A + 2);
    localparam int KW   = ((KA > HW) ? KA : HW) + 1;    // class number incl. out of range
    localparam int LW   = A - LINK_SHIFT;

    // Latched request
    logic          op_reg;
    logic [KW-1:0] k_reg;
    logic [A-1:0]  chunk_reg;

    // Class heads: address payload plus valid flags
    logic [A-1:0]           heads_reg [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] heads_valid_reg, heads_valid_next;

    logic [A-1:0]  heap_start_reg, heap_start_next;
    logic [A:0]    heap_end_reg, heap_end_next;
    logic [A:0]    bump_reg, bump_next;
    logic [31:0]   total_reg, total_next;
    logic [A-1:0]  result_reg, result_next;
    logic          status_reg, status_next;

    // Class of the incoming size
    logic [RW-1:0] r_eff;
    logic [RW-1:0] rnd;
    logic [KW-1:0] k_in;

    always_comb
    begin
        r_eff = (request_size == '0) ? RW'(MIN_CHUNK_BYTES) : RW'(request_size);
        rnd   = (r_eff + RW'(MIN_CHUNK_BYTES - 1)) & ~RW'(MIN_CHUNK_BYTES - 1);
        k_in  = KW'(bit_length(64'(rnd - RW'(1))));
    end

    // Head lookup and sizes for the latched class
    logic          in_range;
    logic [HW-1:0] hidx;
    logic          head_valid;
    logic [A-1:0]  head_addr;
    logic [RW-1:0] size_ext;
    logic [31:0]   size32;
    logic [RW-1:0] bump_sum;
    logic          fits;

    assign in_range   = (k_reg < KW'(NUM_CLASSES));
    assign hidx       = k_reg[HW-1:0];
    assign head_valid = heads_valid_reg[hidx];
    assign head_addr  = heads_reg[hidx];
    assign size_ext   = RW'(1) << k_reg;
    assign size32     = 32'(1) << k_reg;
    assign bump_sum   = RW'(bump_reg) + size_ext;
    assign fits       = (bump_sum < RW'(heap_end_reg));

    assign stat.pop_needed = (op_reg == CMD_ALLOC) && in_range && head_valid;

    // Link store
    logic          link_we, link_re;
    logic [LW-1:0] link_waddr, link_raddr;
    logic [A:0]    link_wdata, link_q;

    assign link_we    = cmd.exec && (op_reg == CMD_FREE) && in_range;
    assign link_waddr = chunk_reg[A-1:LINK_SHIFT];
    assign link_wdata = {head_valid, head_addr};
    assign link_re    = cmd.exec && stat.pop_needed;
    assign link_raddr = head_addr[A-1:LINK_SHIFT];

    p2sca_ram #(
        .WIDTH  (A + 1),
        .ADDR_W (LW)
    ) u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_q)
    );

    // Head update port
    logic         head_we;
    logic         head_wvalid;
    logic [A-1:0] head_waddr;

    // Next-state logic for config, bump, total, result
    always_comb
    begin
        heap_start_next  = heap_start_reg;
        heap_end_next    = heap_end_reg;
        bump_next        = bump_reg;
        total_next       = total_reg;
        result_next      = result_reg;
        status_next      = status_reg;
        head_we          = 1'b0;
        head_wvalid      = 1'b0;
        head_waddr       = chunk_reg;

        if (cfg_wr)
        begin
            case (cfg_index)
                CFG_HEAP_START:
                begin
                    heap_start_next = cfg_data[A-1:0];
                    bump_next       = {1'b0, cfg_data[A-1:0]};
                end
                CFG_HEAP_END:
                begin
                    heap_end_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.exec)
        begin
            result_next = '0;
            status_next = STATUS_OK;
            if (op_reg == CMD_ALLOC)
            begin
                if (!in_range)
                begin
                    status_next = STATUS_OOM;
                end
                else if (head_valid)
                begin
                    // finished in the pop step
                end
                else if (!fits)
                begin
                    status_next = STATUS_OOM;
                end
                else
                begin
                    result_next = bump_reg[A-1:0];
                    bump_next   = bump_sum[A:0];
                    total_next  = total_reg + size32;
                end
            end
            else if (in_range)
            begin
                // push onto the class list
                head_we     = 1'b1;
                head_wvalid = 1'b1;
                head_waddr  = chunk_reg;
                total_next  = total_reg - size32;
            end
        end

        if (cmd.pop)
        begin
            result_next = head_addr;
            status_next = STATUS_OK;
            head_we     = 1'b1;
            head_wvalid = link_q[A];
            head_waddr  = link_q[A-1:0];
            total_next  = total_reg + size32;
        end
    end

    always_comb
    begin
        heads_valid_next = heads_valid_reg;
        if (head_we) heads_valid_next[hidx] = head_wvalid;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heads_valid_reg <= '0;
            heap_start_reg  <= '0;
            heap_end_reg    <= (A + 1)'(1) << A;
            bump_reg        <= '0;
            total_reg       <= '0;
            result_reg      <= '0;
            status_reg      <= STATUS_OK;
        end
        else
        begin
            heads_valid_reg <= heads_valid_next;
            heap_start_reg  <= heap_start_next;
            heap_end_reg    <= heap_end_next;
            bump_reg        <= bump_next;
            total_reg       <= total_next;
            result_reg      <= result_next;
            status_reg      <= status_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= command;
            k_reg     <= k_in;
            chunk_reg <= chunk_address;
        end
        if (head_we) heads_reg[hidx] <= head_waddr;
    end

    assign result_address = result_reg;
    assign status         = status_reg;
    assign bytes_in_use   = total_reg;

    // A failed allocate never carries an address
    a_oom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg == STATUS_OOM) |-> (result_reg == '0))
        else $error("out-of-memory result with nonzero address");

    // Byte total moves only in execute or pop steps
    a_total_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.exec || cmd.pop) |=> $stable(total_reg))
        else $error("byte total changed outside a request");

    // Link store is never read and written together
    a_link_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(link_we && link_re))
        else $error("link store read and write in one cycle");

endmodule

`default_nettype wire

/* design/pow2_size_class_allocator.sv */
// Channel  Ports                                                  Dir  Beat taken when
// request  start, busy, command, request_size, chunk_address      in   start && !busy
// result   done, result_address, status, bytes_in_use             out  done, one cycle
// config   cfg_valid, cfg_ready, cfg_index, cfg_data              in   cfg_valid && cfg_ready
//
// Free, bump allocate and failures: the result beat is registered from the execute step;
// an allocate popped from a free list adds a pop step after it, for the registered link read.
// busy is high until the strobe cycle, so a new beat may be accepted as the strobe shows.
// The receiver cannot stall. cfg_ready is tied high; writes are to be made only while idle (not enforced).
// Reset (rst_n low, async) empties every class list and zeroes the byte total and the
// bump pointer; the link store is not cleared.
`default_nettype none

module pow2_size_class_allocator #(
    parameter int HEAP_ADDR_BITS  = p2sca_pkg::DEF_HEAP_ADDR_BITS,
    parameter int NUM_CLASSES     = p2sca_pkg::DEF_NUM_CLASSES,
    parameter int MIN_CHUNK_BYTES = p2sca_pkg::DEF_MIN_CHUNK_BYTES
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               command,
    input  wire logic [HEAP_ADDR_BITS:0]            request_size,
    input  wire logic [HEAP_ADDR_BITS-1:0]          chunk_address,
    output logic                                    done,
    output logic      [HEAP_ADDR_BITS-1:0]          result_address,
    output logic                                    status,
    output logic      [31:0]                        bytes_in_use,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [p2sca_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [HEAP_ADDR_BITS:0]            cfg_data
);
    import p2sca_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    assign cfg_ready = 1'b1;

    // Sequencer
    p2sca_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Class lists, bump pointer, byte total
    p2sca_dp #(
        .HEAP_ADDR_BITS  (HEAP_ADDR_BITS),
        .NUM_CLASSES     (NUM_CLASSES),
        .MIN_CHUNK_BYTES (MIN_CHUNK_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .command        (command),
        .request_size   (request_size),
        .chunk_address  (chunk_address),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_address (result_address),
        .status         (status),
        .bytes_in_use   (bytes_in_use)
    );

endmodule

`default_nettype wire
